>>> sv/gdc_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date calculator.
package gdc_pkg;

    localparam logic [13:0] MAX_YEAR     = 14'd9999;
    // y / 100 for 14-bit y: (y * 5243) >> 19
    localparam logic [12:0] Q100_MUL     = 13'd5243;
    localparam int          Q100_SHIFT   = 19;
    localparam logic [6:0]  CENTURY      = 7'd100;
    // x / 7 for x below 2^22: (x * ceil(2^25 / 7)) >> 25
    localparam logic [22:0] Q7_MUL       = 23'd4793491;
    localparam int          Q7_SHIFT     = 25;
    localparam logic [8:0]  DAYS_YEAR    = 9'd365;
    localparam logic [8:0]  SERIAL_BIAS  = 9'd306;

    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [4:0]  DAY_FIRST    = 5'd1;
    localparam logic [4:0]  DAY_LAST_DEC = 5'd31;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } date_t;

    // after decode: fields checked, century quotients taken
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [13:0] ym;          // year shifted back for Jan/Feb
        logic [7:0]  q100_y;
        logic [7:0]  q100_ym;
        logic        fields_ok;
    } s1_t;

    // after calendar: leap year, neighbor dates, serial terms
    typedef struct packed {
        logic        valid;
        date_t       prev;
        date_t       next;
        logic [21:0] term_a;      // 365 * ym
        logic [11:0] term_b;      // ym/4 - ym/100 + ym/400
        logic [8:0]  moff;
        logic [4:0]  day;
        logic [8:0]  doy;
    } s2_t;

    typedef struct packed {
        logic        valid;
        date_t       prev;
        date_t       next;
        logic [21:0] serial;
        logic [8:0]  doy;
    } s3_t;

    typedef struct packed {
        logic        valid;
        date_t       prev;
        date_t       next;
        logic [21:0] serial;
        logic [8:0]  doy;
        logic [21:0] serm1;
        logic [18:0] q7;
    } s4_t;

    typedef struct packed {
        logic        date_valid;
        date_t       prev;
        date_t       next;
        logic [21:0] serial_day;
        logic [8:0]  day_of_year;
        logic [2:0]  day_of_week;
    } result_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
            4'd2:                    month_len = leap ? 5'd29 : 5'd28;
            default:                 month_len = 5'd31;
        endcase
    endfunction

    // (153*m' - 457)/5 with Jan/Feb counted as months 13/14
    function automatic logic [8:0] month_off(input logic [3:0] m);
        case (m)
            4'd1:    month_off = 9'd306;
            4'd2:    month_off = 9'd337;
            4'd3:    month_off = 9'd0;
            4'd4:    month_off = 9'd31;
            4'd5:    month_off = 9'd61;
            4'd6:    month_off = 9'd92;
            4'd7:    month_off = 9'd122;
            4'd8:    month_off = 9'd153;
            4'd9:    month_off = 9'd184;
            4'd10:   month_off = 9'd214;
            4'd11:   month_off = 9'd245;
            4'd12:   month_off = 9'd275;
            default: month_off = 9'd0;
        endcase
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        case (m)
            4'd1:    cum_days = 9'd0;
            4'd2:    cum_days = 9'd31;
            4'd3:    cum_days = 9'd59;
            4'd4:    cum_days = 9'd90;
            4'd5:    cum_days = 9'd120;
            4'd6:    cum_days = 9'd151;
            4'd7:    cum_days = 9'd181;
            4'd8:    cum_days = 9'd212;
            4'd9:    cum_days = 9'd243;
            4'd10:   cum_days = 9'd273;
            4'd11:   cum_days = 9'd304;
            4'd12:   cum_days = 9'd334;
            default: cum_days = 9'd0;
        endcase
    endfunction

endpackage

>>> sv/gdc_in_if.sv
// Input channel: one date per item.
interface gdc_in_if;
    import gdc_pkg::*;

    logic        valid;
    logic        ready;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [13:0] year_in;

    modport source (output valid, output day_in, output month_in, output year_in,
                    input ready);
    modport sink   (input valid, input day_in, input month_in, input year_in,
                    output ready);
endinterface

>>> sv/gdc_out_if.sv
// Output channel: one result per item.
interface gdc_out_if;
    import gdc_pkg::*;

    logic        valid;
    logic        ready;
    logic        date_valid;
    logic [4:0]  prev_day;
    logic [3:0]  prev_month;
    logic [13:0] prev_year;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
    logic [21:0] serial_day;
    logic [8:0]  day_of_year;
    logic [2:0]  day_of_week;

    modport source (output valid, output date_valid, output prev_day, output prev_month,
                    output prev_year, output next_day, output next_month,
                    output next_year, output serial_day, output day_of_year,
                    output day_of_week, input ready);
    modport sink   (input valid, input date_valid, input prev_day, input prev_month,
                    input prev_year, input next_day, input next_month,
                    input next_year, input serial_day, input day_of_year,
                    input day_of_week, output ready);
endinterface

>>> sv/gregorian_date_calculator_core.sv
// Top level of the Gregorian date calculator: five-stage date pipeline.
//
//   channel   | dir | payload                                             | handshake
//   ----------+-----+-----------------------------------------------------+------------
//   date_in   | in  | day_in, month_in, year_in                           | valid/ready
//   result    | out | date_valid, prev/next date, serial_day, day_of_year,| valid/ready
//             |     | day_of_week                                         |
//
// One item enters per cycle unless the result side stalls a full pipeline.
// The depth is set by the two constant multiplies: y/100 in decode and serial/7
// in the weekday stage, each followed by a register before its product is used.
// Each stage has its own valid bit and holds its contents while the stage after it
// is full and stalled; bubbles close up, so items keep entering while a result waits.
// Reset clears only the valid bits; payload registers load on acceptance.
module gregorian_date_calculator_core (
    input  logic   clk,
    input  logic   rst_n,
    gdc_in_if.sink    date_in,
    gdc_out_if.source result
);
    import gdc_pkg::*;

    date_t   in_date;
    logic    s1_valid;
    logic    s1_ready;
    s1_t     s1_data;
    logic    s2_valid;
    logic    s2_ready;
    s2_t     s2_data;
    logic    s3_valid;
    logic    s3_ready;
    s3_t     s3_data;
    result_t res_data;

    // pack the incoming item
    assign in_date.day   = date_in.day_in;
    assign in_date.month = date_in.month_in;
    assign in_date.year  = date_in.year_in;

    // stage 1: check ranges, shift Jan/Feb into the prior year, divide by 100
    gdc_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (date_in.valid),
        .up_ready (date_in.ready),
        .up_data  (in_date),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_data)
    );

    // stage 2: leap rule, validity, neighbor dates, serial terms
    gdc_calendar u_calendar (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    // stage 3: add up the serial day; invalid dates drop to zero here
    gdc_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (s3_valid),
        .dn_ready (s3_ready),
        .dn_data  (s3_data)
    );

    // stages 4 and 5: weekday from serial mod 7, then the output register
    gdc_weekday u_weekday (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_ready (s3_ready),
        .up_data  (s3_data),
        .dn_valid (result.valid),
        .dn_ready (result.ready),
        .dn_data  (res_data)
    );

    // unpack the result item
    assign result.date_valid  = res_data.date_valid;
    assign result.prev_day    = res_data.prev.day;
    assign result.prev_month  = res_data.prev.month;
    assign result.prev_year   = res_data.prev.year;
    assign result.next_day    = res_data.next.day;
    assign result.next_month  = res_data.next.month;
    assign result.next_year   = res_data.next.year;
    assign result.serial_day  = res_data.serial_day;
    assign result.day_of_year = res_data.day_of_year;
    assign result.day_of_week = res_data.day_of_week;
endmodule

>>> sv/gdc_decode.sv
// Stage 1: range checks, Jan/Feb year shift and century quotients.
module gdc_decode (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  gdc_pkg::date_t up_data,
    output logic           dn_valid,
    input  logic           dn_ready,
    output gdc_pkg::s1_t   dn_data
);
    import gdc_pkg::*;

    logic        valid_reg;
    s1_t         data_reg;
    s1_t         data_next;
    logic        jan_feb;
    logic [26:0] prod_y;
    logic [26:0] prod_ym;

    always_comb
    begin
        jan_feb   = (up_data.month == MONTH_JAN) || (up_data.month == MONTH_FEB);
        data_next.day   = up_data.day;
        data_next.month = up_data.month;
        data_next.year  = up_data.year;
        data_next.ym    = jan_feb ? (up_data.year - 14'd1) : up_data.year;
        prod_y    = 27'(up_data.year) * 27'(Q100_MUL);
        prod_ym   = 27'(data_next.ym) * 27'(Q100_MUL);
        data_next.q100_y  = prod_y[Q100_SHIFT +: 8];
        data_next.q100_ym = prod_ym[Q100_SHIFT +: 8];
        data_next.fields_ok = (up_data.month >= MONTH_JAN) && (up_data.month <= MONTH_DEC)
                            && (up_data.year != 14'd0) && (up_data.year <= MAX_YEAR)
                            && (up_data.day != 5'd0);
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end
endmodule

>>> sv/gdc_calendar.sv
// Stage 2: leap year, validity, previous and next date, serial terms.
module gdc_calendar (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  gdc_pkg::s1_t up_data,
    output logic         dn_valid,
    input  logic         dn_ready,
    output gdc_pkg::s2_t dn_data
);
    import gdc_pkg::*;

    logic        valid_reg;
    s2_t         data_reg;
    s2_t         data_next;
    logic [14:0] cent_y;
    logic        cent_year;
    logic        leap;
    logic [4:0]  mlen;
    logic [3:0]  m_dec;

    always_comb
    begin
        cent_y    = 15'(up_data.q100_y) * 15'(CENTURY);
        cent_year = (cent_y == {1'b0, up_data.year});
        // divisible by 4 and not by 100, or by 400 (century quotient divisible by 4)
        leap = ((up_data.year[1:0] == 2'd0) && !cent_year)
            || (cent_year && (up_data.q100_y[1:0] == 2'd0));
        mlen  = month_len(up_data.month, leap);
        m_dec = up_data.month - 4'd1;

        data_next.valid = up_data.fields_ok && (up_data.day <= mlen);

        // previous date: step back across month and year ends
        data_next.prev.day   = up_data.day - 5'd1;
        data_next.prev.month = up_data.month;
        data_next.prev.year  = up_data.year;
        if (up_data.day == DAY_FIRST)
        begin
            if (up_data.month > MONTH_JAN)
            begin
                data_next.prev.month = m_dec;
                data_next.prev.day   = month_len(m_dec, leap);
            end
            else
            begin
                data_next.prev.day   = DAY_LAST_DEC;
                data_next.prev.month = MONTH_DEC;
                data_next.prev.year  = up_data.year - 14'd1;
            end
        end

        // next date
        data_next.next.day   = up_data.day + 5'd1;
        data_next.next.month = up_data.month;
        data_next.next.year  = up_data.year;
        if (up_data.day == mlen)
        begin
            data_next.next.day = DAY_FIRST;
            if (up_data.month < MONTH_DEC)
                data_next.next.month = up_data.month + 4'd1;
            else
            begin
                data_next.next.month = MONTH_JAN;
                data_next.next.year  = up_data.year + 14'd1;
            end
        end

        data_next.term_a = 22'(up_data.ym) * 22'(DAYS_YEAR);
        data_next.term_b = 12'(up_data.ym >> 2) - 12'(up_data.q100_ym)
                         + 12'(up_data.q100_ym >> 2);
        data_next.moff   = month_off(up_data.month);
        data_next.day    = up_data.day;
        data_next.doy    = cum_days(up_data.month) + 9'(up_data.day)
                         + 9'(leap && (up_data.month > MONTH_FEB));
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end
endmodule

>>> sv/gdc_serial.sv
// Stage 3: serial day sum; zero every field of an invalid date.
module gdc_serial (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  gdc_pkg::s2_t up_data,
    output logic         dn_valid,
    input  logic         dn_ready,
    output gdc_pkg::s3_t dn_data
);
    import gdc_pkg::*;

    logic        valid_reg;
    s3_t         data_reg;
    s3_t         data_next;
    logic [21:0] serial;

    always_comb
    begin
        serial = up_data.term_a + 22'(up_data.term_b) + 22'(up_data.moff)
               + 22'(up_data.day) - 22'(SERIAL_BIAS);
        data_next.valid = up_data.valid;
        if (up_data.valid)
        begin
            data_next.prev   = up_data.prev;
            data_next.next   = up_data.next;
            data_next.serial = serial;
            data_next.doy    = up_data.doy;
        end
        else
        begin
            data_next.prev   = '0;
            data_next.next   = '0;
            data_next.serial = '0;
            data_next.doy    = '0;
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end
endmodule

>>> sv/gdc_weekday.sv
// Stages 4 and 5: weekday by reciprocal multiply, then the output register.
module gdc_weekday (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  gdc_pkg::s3_t     up_data,
    output logic             dn_valid,
    input  logic             dn_ready,
    output gdc_pkg::result_t dn_data
);
    import gdc_pkg::*;

    logic        q_valid_reg;
    s4_t         q_reg;
    s4_t         q_next;
    logic        q_ready;
    logic [44:0] prod;

    logic        o_valid_reg;
    result_t     o_reg;
    result_t     o_next;
    logic [21:0] q7x7;
    logic [21:0] rem;

    // stage 4: quotient of (serial - 1) / 7
    always_comb
    begin
        q_next.valid  = up_data.valid;
        q_next.prev   = up_data.prev;
        q_next.next   = up_data.next;
        q_next.serial = up_data.serial;
        q_next.doy    = up_data.doy;
        q_next.serm1  = up_data.serial - 22'd1;
        prod          = 45'(q_next.serm1) * 45'(Q7_MUL);
        q_next.q7     = prod[Q7_SHIFT +: 19];
    end

    assign up_ready = !q_valid_reg || q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (up_ready)
            q_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            q_reg <= q_next;
    end

    // stage 5: remainder, weekday, result register
    always_comb
    begin
        q7x7 = {q_reg.q7, 3'b000} - 22'(q_reg.q7);
        rem  = q_reg.serm1 - q7x7;
        o_next.date_valid  = q_reg.valid;
        o_next.prev        = q_reg.prev;
        o_next.next        = q_reg.next;
        o_next.serial_day  = q_reg.serial;
        o_next.day_of_year = q_reg.doy;
        o_next.day_of_week = q_reg.valid ? (rem[2:0] + 3'd1) : 3'd0;
    end

    assign q_ready  = !o_valid_reg || dn_ready;
    assign dn_valid = o_valid_reg;
    assign dn_data  = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (q_ready)
            o_valid_reg <= q_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_valid_reg && q_ready)
            o_reg <= o_next;
    end
endmodule

>>> dv/testbench.sv
// Self-checking testbench for the Gregorian date calculator core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gdc_pkg::*;

    // Near the end of the stimulus, drop all idling on both sides.
    localparam int QUIET_TAIL = 150;
    // Cycles to wait after the last result; the pipeline is five stages deep.
    localparam int DRAIN_CYCLES = 12;

    logic clk = 1'b0;
    logic rst_n;

    gdc_in_if  date_ch ();
    gdc_out_if res_ch ();

    gregorian_date_calculator_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .date_in (date_ch),
        .result  (res_ch)
    );

    // Dates waiting to be driven, and results owed by the block, oldest first.
    date_t   dates_pending[$];
    result_t results_due[$];

    int   total_dates;
    int   dates_taken;
    int   mismatches;
    int   real_dates;
    int   rejected_dates;
    int   year_turns;
    int   leap_days;
    logic in_taken;
    int   in_hold;
    int   out_hold;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in(int unsigned m, int unsigned y);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap_year(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Work out the full result for one date. Days are counted from the
    // start of year 1, so the first day of all gets serial 1 (a Monday).
    function automatic result_t predict_date(date_t dt);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned yb;
        int unsigned doy;
        int unsigned ser;
        int unsigned k;
        result_t     r;
        r = '0;
        d = dt.day;
        m = dt.month;
        y = dt.year;
        // Anything that is not a real date gives an all-zero result.
        if (m < 1 || m > 12 || y < 1 || y > MAX_YEAR || d < 1 || d > days_in(m, y))
            return r;

        r.date_valid = 1'b1;

        // Step back one day; the day before 1 Jan of year 1 lands in year 0.
        r.prev.day   = 5'(d - 1);
        r.prev.month = 4'(m);
        r.prev.year  = 14'(y);
        if (d == 1)
        begin
            if (m > 1)
            begin
                r.prev.month = 4'(m - 1);
                r.prev.day   = 5'(days_in(m - 1, y));
            end
            else
            begin
                r.prev.day   = 5'(31);
                r.prev.month = 4'(12);
                r.prev.year  = 14'(y - 1);
            end
        end

        // Step forward one day; after 31 Dec 9999 the year reads 10000.
        r.next.day   = 5'(d + 1);
        r.next.month = 4'(m);
        r.next.year  = 14'(y);
        if (d == days_in(m, y))
        begin
            r.next.day = 5'(1);
            if (m < 12)
                r.next.month = 4'(m + 1);
            else
            begin
                r.next.month = 4'(1);
                r.next.year  = 14'(y + 1);
            end
        end

        // Ordinal day: sum the lengths of the months already gone by.
        doy = d;
        for (k = 1; k < m; k++)
            doy += days_in(k, y);
        yb  = y - 1;
        ser = 365 * yb + yb / 4 - yb / 100 + yb / 400 + doy;

        r.serial_day  = 22'(ser);
        r.day_of_year = 9'(doy);
        r.day_of_week = 3'((ser - 1) % 7 + 1);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    task automatic push_date(int unsigned d, int unsigned m, int unsigned y);
        date_t dt;
        dt.day   = 5'(d);
        dt.month = 4'(m);
        dt.year  = 14'(y);
        dates_pending.push_back(dt);
    endtask

    // A real date, leaning toward month ends and century years where the
    // carries and the leap rule do their work.
    task automatic push_real_date();
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned len;
        if ($urandom_range(0, 9) == 0)
            y = $urandom_range(1, 99) * 100;
        else
            y = $urandom_range(1, 9999);
        m   = $urandom_range(1, 12);
        len = days_in(m, y);
        case ($urandom_range(0, 9))
            0:       d = 1;
            1, 2:    d = len;
            3:       d = len - 1;
            default: d = $urandom_range(1, len);
        endcase
        push_date(d, m, y);
    endtask

    // Raw field values over the whole input range, valid or not.
    task automatic push_noise_date();
        int unsigned y;
        if ($urandom_range(0, 9) == 0)
            y = $urandom_range(10000, 16383);
        else
            y = $urandom_range(0, 9999);
        push_date($urandom_range(0, 31), $urandom_range(0, 15), y);
    endtask

    // Idle in stretches: none in the final items, and none in a window of
    // every few hundred so that back-to-back traffic is seen too.
    function automatic bit idling_allowed();
        int unsigned left;
        left = dates_pending.size();
        return (left > QUIET_TAIL) && (left % 300 >= 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: advance to the next date once the current one is taken
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (date_ch.valid && !in_taken)
            begin
                // hold the item until the block takes it
            end
            else if (in_hold > 0)
            begin
                in_hold--;
                date_ch.valid <= 1'b0;
            end
            else if (dates_pending.size() > 0 && idling_allowed() &&
                     $urandom_range(0, 7) == 0)
            begin
                in_hold = $urandom_range(0, 2);
                date_ch.valid <= 1'b0;
            end
            else if (dates_pending.size() > 0)
            begin
                date_t dt;
                dt = dates_pending.pop_front();
                date_ch.valid    <= 1'b1;
                date_ch.day_in   <= dt.day;
                date_ch.month_in <= dt.month;
                date_ch.year_in  <= dt.year;
            end
            else
                date_ch.valid <= 1'b0;
        end
    end

    // Result side back-pressure, in bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_hold > 0)
            begin
                out_hold--;
                res_ch.ready <= 1'b0;
            end
            else if (idling_allowed() && $urandom_range(0, 7) == 0)
            begin
                out_hold = $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on acceptance, compare on delivery
    // ------------------------------------------------------------------

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            // Retire the oldest expectation before adding the new one, so
            // the outcome never depends on process order within the edge.
            if (res_ch.valid && res_ch.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result delivered with no date outstanding");
                    mismatches++;
                end
                else
                begin
                    result_t want;
                    want = results_due.pop_front();
                    check_field("date_valid",  want.date_valid,  res_ch.date_valid);
                    check_field("prev_day",    want.prev.day,    res_ch.prev_day);
                    check_field("prev_month",  want.prev.month,  res_ch.prev_month);
                    check_field("prev_year",   want.prev.year,   res_ch.prev_year);
                    check_field("next_day",    want.next.day,    res_ch.next_day);
                    check_field("next_month",  want.next.month,  res_ch.next_month);
                    check_field("next_year",   want.next.year,   res_ch.next_year);
                    check_field("serial_day",  want.serial_day,  res_ch.serial_day);
                    check_field("day_of_year", want.day_of_year, res_ch.day_of_year);
                    check_field("day_of_week", want.day_of_week, res_ch.day_of_week);
                end
            end

            if (date_ch.valid && date_ch.ready)
            begin
                date_t   dt;
                result_t want;
                dt.day   = date_ch.day_in;
                dt.month = date_ch.month_in;
                dt.year  = date_ch.year_in;
                want     = predict_date(dt);
                results_due.push_back(want);
                dates_taken++;
                if (want.date_valid)
                begin
                    real_dates++;
                    if (want.next.year != dt.year || want.prev.year != dt.year)
                        year_turns++;
                    if (dt.month == MONTH_FEB && dt.day == 5'd29)
                        leap_days++;
                end
                else
                    rejected_dates++;
            end

            in_taken <= date_ch.valid && date_ch.ready;
        end
    end

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    initial
    begin
        int n;
        rst_n            = 1'b0;
        date_ch.valid    = 1'b0;
        date_ch.day_in   = '0;
        date_ch.month_in = '0;
        date_ch.year_in  = '0;
        res_ch.ready     = 1'b0;
        dates_taken      = 0;
        mismatches       = 0;
        real_dates       = 0;
        rejected_dates   = 0;
        year_turns       = 0;
        leap_days        = 0;
        in_hold          = 0;
        out_hold         = 0;

        // Directed dates: first and last day of all, leap rule corners,
        // month ends, and every way a date can be rejected.
        push_date(DAY_FIRST, MONTH_JAN, 1);
        push_date(DAY_LAST_DEC, MONTH_DEC, MAX_YEAR);
        push_date(DAY_LAST_DEC, MONTH_DEC, 1);
        push_date(DAY_FIRST, MONTH_JAN, MAX_YEAR);
        push_date(29, MONTH_FEB, 2000);
        push_date(29, MONTH_FEB, 1900);
        push_date(29, MONTH_FEB, 2024);
        push_date(29, MONTH_FEB, 2023);
        push_date(28, MONTH_FEB, 2023);
        push_date(DAY_FIRST, 3, 2000);
        push_date(DAY_FIRST, 3, 2100);
        push_date(31, 12, 2000);
        push_date(30, 4, 8191);
        push_date(31, 4, 8192);
        push_date(15, 7, 16383);
        push_date(10, 10, 10000);
        push_date(0, 5, 1234);
        push_date(31, 0, 1234);
        push_date(1, 13, 1234);
        push_date(31, 15, 9999);
        push_date(1, 1, 0);
        push_date(31, 5, 5555);
        push_date(30, 11, 4000);
        push_date(1, 8, 1582);

        // Random part: mostly real dates, the rest raw field noise.
        n = 1350 - dates_pending.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                push_noise_date();
            else
                push_real_date();
        end
        total_dates = dates_pending.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every date to be taken and every result to be checked,
        // then let the pipeline sit so any stray result shows up.
        while (dates_taken < total_dates || results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d dates checked, %0d real and %0d rejected",
                 dates_taken, real_dates, rejected_dates);
        $display("summary: %0d on a year boundary, %0d on a leap day",
                 year_turns, leap_days);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
sv/gdc_pkg.sv
sv/gdc_in_if.sv
sv/gdc_out_if.sv
sv/gdc_decode.sv
sv/gdc_calendar.sv
sv/gdc_serial.sv
sv/gdc_weekday.sv
sv/gregorian_date_calculator_core.sv
dv/testbench.sv
